>>> design/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg: shared types and constants of the string escape decoder
// Holds the escape phase codes, the quote mode codes, the character codes
// used by the decoder and the structs passed between the decoder, the output
// buffer and the top level.
// ----------------------------------------------------------------------------
package sed_pkg;

   // Escape phase codes
   typedef enum logic [2:0] {
      PH_NORMAL = 3'd0,
      PH_ESC    = 3'd1,
      PH_HEX0   = 3'd2,
      PH_HEX1   = 3'd3,
      PH_OCT1   = 3'd4,
      PH_OCT2   = 3'd5
   } sed_phase_type;

   // Quote mode codes; any other value acts as an other-delimiter literal
   localparam logic [1:0] QM_SINGLE = 2'd0;
   localparam logic [1:0] QM_DOUBLE = 2'd1;
   localparam logic [1:0] QM_OTHER  = 2'd2;

   // Register index of the quote mode register
   localparam logic REG_QUOTE_MODE = 1'b0;

   // Character codes
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LOW_X  = 8'h78;
   localparam logic [7:0] CH_UP_X   = 8'h58;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_V  = 8'h76;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;

   localparam int unsigned MAX_OUT = 3;

   // Escape state carried from one item to the next
   typedef struct packed {
      sed_phase_type phase;
      logic [7:0]    digit;
      logic          upper;
   } sed_state_type;

   // Result bytes of one item, lowest index first
   typedef struct packed {
      logic [MAX_OUT-1:0][7:0] data;
      logic [1:0]              cnt;
      logic                    last;
   } sed_res_type;

endpackage

>>> design/sed_decode.sv
// ----------------------------------------------------------------------------
// sed_decode: escape decoding of one raw byte
// Given the escape state and one raw byte, produces up to three result bytes,
// the end-of-string mark and the next escape state.
// ----------------------------------------------------------------------------
module sed_decode (
   input  logic [1:0]             quote_mode,
   input  sed_pkg::sed_state_type cur_state,
   input  logic [7:0]             raw_byte,
   input  logic                   end_of_string,
   output sed_pkg::sed_state_type nxt_state,
   output sed_pkg::sed_res_type   res
);
   import sed_pkg::*;

   // Append one byte to the result list
   function automatic sed_res_type put(input sed_res_type r, input logic [7:0] b);
      sed_res_type o;
      o = r;
      if (r.cnt != 2'd3) begin
         o.data[r.cnt] = b;
         o.cnt         = r.cnt + 2'd1;
      end
      return o;
   endfunction

   // Hex digit value, 16 when not a hex digit
   function automatic logic [4:0] hex_val(input logic [7:0] b);
      logic [4:0] v;
      v = 5'd16;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = 5'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         v = 5'(b - 8'h61 + 8'd10);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         v = 5'(b - 8'h41 + 8'd10);
      end
      return v;
   endfunction

   logic [4:0] hv;
   logic       is_oct;
   logic       is_hex;
   logic [7:0] x_char;

   assign hv     = hex_val(raw_byte);
   assign is_hex = ~hv[4];
   assign is_oct = (raw_byte >= 8'h30) && (raw_byte <= 8'h37);
   assign x_char = cur_state.upper ? CH_UP_X : CH_LOW_X;

   always_comb begin
      sed_res_type   r;
      sed_state_type s;
      logic          do_plain;
      r        = '0;
      s        = cur_state;
      do_plain = 1'b0;

      // Consume the byte under the current phase
      case (cur_state.phase)
         PH_ESC: begin
            s.phase = PH_NORMAL;
            if (quote_mode == QM_SINGLE) begin
               if (raw_byte == CH_BSLASH || raw_byte == CH_SQUOTE) begin
                  r = put(r, raw_byte);
               end else begin
                  r = put(r, CH_BSLASH);
                  r = put(r, raw_byte);
               end
            end else begin
               case (raw_byte)
                  CH_LOW_N:  r = put(r, CH_LF);
                  CH_LOW_T:  r = put(r, CH_TAB);
                  CH_LOW_R:  r = put(r, CH_CR);
                  CH_LOW_V:  r = put(r, CH_VT);
                  CH_LOW_F:  r = put(r, CH_FF);
                  CH_BSLASH,
                  CH_DOLLAR: r = put(r, raw_byte);
                  CH_DQUOTE: begin
                     if (quote_mode != QM_DOUBLE) begin
                        r = put(r, CH_BSLASH);
                     end
                     r = put(r, CH_DQUOTE);
                  end
                  CH_LOW_X,
                  CH_UP_X: begin
                     s.upper = (raw_byte == CH_UP_X);
                     s.phase = PH_HEX0;
                  end
                  default: begin
                     if (is_oct) begin
                        s.digit = {5'd0, raw_byte[2:0]};
                        s.phase = PH_OCT1;
                     end else begin
                        r = put(r, CH_BSLASH);
                        r = put(r, raw_byte);
                     end
                  end
               endcase
            end
         end
         PH_HEX0: begin
            if (is_hex) begin
               s.digit = {4'd0, hv[3:0]};
               s.phase = PH_HEX1;
            end else begin
               r        = put(r, CH_BSLASH);
               r        = put(r, x_char);
               s.phase  = PH_NORMAL;
               do_plain = 1'b1;
            end
         end
         PH_HEX1: begin
            s.phase = PH_NORMAL;
            if (is_hex) begin
               r = put(r, {cur_state.digit[3:0], hv[3:0]});
            end else begin
               r        = put(r, cur_state.digit);
               do_plain = 1'b1;
            end
         end
         PH_OCT1: begin
            if (is_oct) begin
               s.digit = {cur_state.digit[4:0], raw_byte[2:0]};
               s.phase = PH_OCT2;
            end else begin
               r        = put(r, cur_state.digit);
               s.phase  = PH_NORMAL;
               do_plain = 1'b1;
            end
         end
         PH_OCT2: begin
            s.phase = PH_NORMAL;
            if (is_oct) begin
               r = put(r, {cur_state.digit[4:0], raw_byte[2:0]});
            end else begin
               r        = put(r, cur_state.digit);
               do_plain = 1'b1;
            end
         end
         default: begin
            s.phase  = PH_NORMAL;
            do_plain = 1'b1;
         end
      endcase

      // Handle the byte as ordinary text
      if (do_plain) begin
         if (raw_byte == CH_BSLASH) begin
            s.phase = PH_ESC;
         end else begin
            r = put(r, raw_byte);
         end
      end

      // Flush a pending escape at the end of the literal; the x letter may
      // have arrived with this very byte
      if (end_of_string) begin
         case (s.phase)
            PH_ESC:  r = put(r, CH_BSLASH);
            PH_HEX0: begin
               r = put(r, CH_BSLASH);
               r = put(r, s.upper ? CH_UP_X : CH_LOW_X);
            end
            PH_HEX1,
            PH_OCT1,
            PH_OCT2: r = put(r, s.digit);
            default: ;
         endcase
         s.phase = PH_NORMAL;
         s.digit = 8'd0;
         s.upper = 1'b0;
      end

      r.last    = end_of_string;
      res       = r;
      nxt_state = s;
   end

endmodule

>>> design/sed_out_buf.sv
// ----------------------------------------------------------------------------
// sed_out_buf: result register of the escape decoder
// Holds the up to three bytes of one decoded item and hands them out one
// per cycle while rsp_tready is high; takes the next item's bytes as its last byte leaves.
// ----------------------------------------------------------------------------
module sed_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  sed_pkg::sed_res_type res,
   output logic                 can_load,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // decoded_byte[7:0]
   output logic                 rsp_tlast    // last_of_string
);
   import sed_pkg::*;

   logic [MAX_OUT-1:0][7:0] data_ff, data_in;
   logic [1:0]              cnt_ff, cnt_in;
   logic                    last_ff, last_in;
   logic                    pop;

   assign pop        = rsp_tvalid & rsp_tready;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = data_ff[0];
   assign rsp_tlast  = last_ff & (cnt_ff == 2'd1);
   assign can_load   = (cnt_ff == 2'd0) | ((cnt_ff == 2'd1) & rsp_tready);

   // Load a new item or advance the queue by one byte
   always_comb begin
      data_in = data_ff;
      cnt_in  = cnt_ff;
      last_in = last_ff;
      if (load) begin
         data_in = res.data;
         cnt_in  = res.cnt;
         last_in = res.last;
      end else if (pop) begin
         data_in[0] = data_ff[1];
         data_in[1] = data_ff[2];
         cnt_in     = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         last_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         last_ff <= last_in;
      end
      data_ff <= data_in;
   end

endmodule

>>> design/string_escape_decoder.sv
// ----------------------------------------------------------------------------
// string_escape_decoder: unescapes the body of a quoted string literal
// Raw bytes enter one per item with an end mark; escape sequences are
// decoded under the configured quote mode and the plain bytes stream out.
//
//   Channel  Dir  Payload                          Handshake
//   req_     in   tdata raw_byte, tlast end mark   tvalid/tready
//   rsp_     out  tdata decoded_byte, tlast last   tvalid/tready
//   csr_     in   quote_mode at byte address 0     APB, pready high
//
// An item is registered in the input register, then its results load into the
// result register. One item per cycle when rsp_ is ready and each item yields
// at most one byte; an item with two or three bytes holds the next item in the
// input register until its last byte leaves the single result port. Reset is
// synchronous and clears the escape state and quote_mode to double-quoted; a
// stalled rsp_ side stalls req_ once the input register is also full.
// ----------------------------------------------------------------------------
module string_escape_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // raw_byte[7:0]
   input  logic        req_tlast,    // end_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // decoded_byte[7:0]
   output logic        rsp_tlast,    // last_of_string
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sed_pkg::*;

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff, in_byte_in;
   logic          in_end_ff, in_end_in;
   sed_state_type state_ff, state_in, dec_state;
   sed_res_type   dec_res;
   logic [1:0]    mode_ff, mode_in;
   logic          can_load;
   logic          fire;
   logic          req_acc;
   logic          csr_wr;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_QUOTE_MODE) ? {30'd0, mode_ff} : 32'd0;

   always_comb begin
      mode_in = mode_ff;
      if (csr_wr && csr_paddr[2] == REG_QUOTE_MODE) begin
         mode_in = csr_pwdata[1:0];
      end
   end

   // Input register: move on when the result register can take the item
   assign fire       = in_valid_ff & can_load;
   assign req_tready = ~in_valid_ff | fire;
   assign req_acc    = req_tvalid & req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (req_acc) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_end_in   = req_tlast;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Advance the escape state with each decoded item
   always_comb begin
      state_in = state_ff;
      if (fire) begin
         state_in = dec_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '{phase: PH_NORMAL, digit: 8'd0, upper: 1'b0};
         mode_ff     <= QM_DOUBLE;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         mode_ff     <= mode_in;
      end
      in_byte_ff <= in_byte_in;
      in_end_ff  <= in_end_in;
   end

   sed_decode u_decode (
      .quote_mode    (mode_ff),
      .cur_state     (state_ff),
      .raw_byte      (in_byte_ff),
      .end_of_string (in_end_ff),
      .nxt_state     (dec_state),
      .res           (dec_res)
   );

   sed_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .res        (dec_res),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // An end-marked item always yields a byte
   a_end_yields : assert property (@(posedge clock) disable iff (reset)
      fire && in_end_ff |-> dec_res.cnt != 2'd0)
      else $error("end-marked item produced no result");

   // The escape state is cleared after the end of a literal
   a_end_clears : assert property (@(posedge clock) disable iff (reset)
      fire && in_end_ff |=> state_ff.phase == PH_NORMAL && state_ff.digit == 8'd0)
      else $error("escape state not cleared after end of literal");

   // A held input item is never dropped
   a_hold_item : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input item lost");
`endif

endmodule

>>> dv/string_escape_decoder_test.sv
// ----------------------------------------------------------------------------
// string_escape_decoder_test: self-checking bench for the escape decoder
// Feeds literal bodies byte by byte on req_, predicts the unescaped bytes
// with a behavioral decoder kept beside the block, and compares every rsp_
// item in order. quote_mode is rewritten between phases, sometimes while an
// escape is still pending, and both sides stall at random.
// ----------------------------------------------------------------------------
module string_escape_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sed_pkg::*;

   localparam logic [2:0] QUOTE_MODE_ADDR = {REG_QUOTE_MODE, 2'b00};
   localparam logic [1:0] QM_ALIAS = 2'd3;   // acts as other delimiter

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;

   localparam int SETTLE_CYCLES = 12;
   localparam int LONG_HOLD     = 200;
   localparam int PHASE_ITEMS   = 40;

   typedef struct packed {
      logic [7:0] raw;
      logic       eos;
   } raw_item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } decoded_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // raw_byte[7:0]
   logic        req_tlast = 1'b0;     // end_of_string
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;            // decoded_byte[7:0]
   logic        rsp_tlast;            // last_of_string
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   string_escape_decoder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Decoder shadow state
   logic [1:0]    quote_mode_shadow = QM_DOUBLE;
   sed_phase_type esc_state = PH_NORMAL;
   logic [7:0]    held_value = 8'd0;
   logic          held_upper = 1'b0;
   logic [7:0]    step_bytes[$];

   raw_item_type     raw_items[$];
   decoded_item_type expected_bytes[$];
   int            idle_style = 0;
   int            mismatch_count = 0;
   int            results_seen = 0;
   int            req_gap = 0;
   int            rsp_wait = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Behavioral decoder
   // ------------------------------------------------------------------------
   function automatic logic is_octal(logic [7:0] b);
      return b >= CH_ZERO && b <= CH_SEVEN;
   endfunction

   // 16 marks a byte that is not a hex digit
   function automatic logic [4:0] hex_digit_value(logic [7:0] b);
      if (b >= CH_ZERO && b <= CH_NINE) return 5'(b - CH_ZERO);
      if (b >= CH_LOW_A && b <= CH_LOW_F) return 5'(b - CH_LOW_A + 8'd10);
      if (b >= CH_UP_A && b <= CH_UP_F) return 5'(b - CH_UP_A + 8'd10);
      return 5'd16;
   endfunction

   function automatic void emit(logic [7:0] b);
      if (step_bytes.size() < MAX_OUT) step_bytes.push_back(b);
   endfunction

   function automatic void take_plain(logic [7:0] b);
      if (b == CH_BSLASH) esc_state = PH_ESC;
      else emit(b);
   endfunction

   function automatic void take_escaped(logic [7:0] b);
      esc_state = PH_NORMAL;
      if (quote_mode_shadow == QM_SINGLE) begin
         if (b == CH_BSLASH || b == CH_SQUOTE) begin
            emit(b);
         end else begin
            emit(CH_BSLASH);
            emit(b);
         end
         return;
      end
      case (b)
         CH_LOW_N: emit(CH_LF);
         CH_LOW_T: emit(CH_TAB);
         CH_LOW_R: emit(CH_CR);
         CH_LOW_V: emit(CH_VT);
         CH_LOW_F: emit(CH_FF);
         CH_BSLASH, CH_DOLLAR: emit(b);
         CH_DQUOTE: begin
            if (quote_mode_shadow != QM_DOUBLE) emit(CH_BSLASH);
            emit(CH_DQUOTE);
         end
         CH_LOW_X, CH_UP_X: begin
            held_upper = (b == CH_UP_X);
            esc_state = PH_HEX0;
         end
         default: begin
            if (is_octal(b)) begin
               held_value = b - CH_ZERO;
               esc_state = PH_OCT1;
            end else begin
               emit(CH_BSLASH);
               emit(b);
            end
         end
      endcase
   endfunction

   // Advance the shadow decoder by one raw byte and queue its output bytes
   function automatic void predict_decode(logic [7:0] b, logic eos);
      logic [4:0] h;
      step_bytes.delete();
      case (esc_state)
         PH_ESC: take_escaped(b);
         PH_HEX0: begin
            h = hex_digit_value(b);
            if (h < 5'd16) begin
               held_value = 8'(h);
               esc_state = PH_HEX1;
            end else begin
               emit(CH_BSLASH);
               emit(held_upper ? CH_UP_X : CH_LOW_X);
               esc_state = PH_NORMAL;
               take_plain(b);
            end
         end
         PH_HEX1: begin
            h = hex_digit_value(b);
            esc_state = PH_NORMAL;
            if (h < 5'd16) begin
               emit(8'(held_value * 16 + h));
            end else begin
               emit(held_value);
               take_plain(b);
            end
         end
         PH_OCT1: begin
            if (is_octal(b)) begin
               held_value = 8'(held_value * 8 + (b - CH_ZERO));
               esc_state = PH_OCT2;
            end else begin
               emit(held_value);
               esc_state = PH_NORMAL;
               take_plain(b);
            end
         end
         PH_OCT2: begin
            esc_state = PH_NORMAL;
            if (is_octal(b)) begin
               emit(8'(held_value * 8 + (b - CH_ZERO)));
            end else begin
               emit(held_value);
               take_plain(b);
            end
         end
         default: begin
            esc_state = PH_NORMAL;
            take_plain(b);
         end
      endcase

      // Flush whatever escape is still open at the end mark
      if (eos) begin
         case (esc_state)
            PH_ESC: emit(CH_BSLASH);
            PH_HEX0: begin
               emit(CH_BSLASH);
               emit(held_upper ? CH_UP_X : CH_LOW_X);
            end
            PH_HEX1, PH_OCT1, PH_OCT2: emit(held_value);
            default: ;
         endcase
         esc_state = PH_NORMAL;
         held_value = 8'd0;
         held_upper = 1'b0;
      end

      foreach (step_bytes[i])
         expected_bytes.push_back('{data: step_bytes[i],
                                    last: eos && (i == step_bytes.size() - 1)});
   endfunction

   function automatic int draw_idle(int style);
      case (style % 3)
         0: return 0;
         1: return $urandom_range(0, 19);
         default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Driver: offer queued items, predict on each accepted one
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      raw_item_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) predict_decode(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_tvalid <= 1'b0;
               req_gap <= req_gap - 1;
            end else if (raw_items.size() != 0) begin
               next_item = raw_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= next_item.raw;
               req_tlast <= next_item.eos;
               req_gap <= draw_idle(idle_style);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check each result item against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      decoded_item_type want;
      int wait_n;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait <= 0;
      end else begin
         wait_n = rsp_wait;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected item: expected none, actual data %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.data) begin
                  $display("%0t: decoded_byte mismatch: expected %h, actual %h",
                           $time, want.data, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last_of_string mismatch: expected %b, actual %b",
                           $time, want.last, rsp_tlast);
                  mismatch_count++;
               end
            end
            results_seen++;
            // hold off long enough for the block to back up into req_
            if (results_seen == 60 || results_seen == 260) wait_n = LONG_HOLD;
            else wait_n = draw_idle(idle_style + 1);
         end else if (wait_n != 0) begin
            wait_n--;
         end
         rsp_wait <= wait_n;
         rsp_tready <= (wait_n == 0);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_item(logic [7:0] b, logic eos);
      raw_items.push_back('{raw: b, eos: eos});
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) push_item(s[i], i == s.len() - 1);
   endtask

   task automatic write_quote_mode(logic [1:0] mode);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= QUOTE_MODE_ADDR;
      csr_pwdata <= {30'd0, mode};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      quote_mode_shadow = mode;
      @(negedge clock);
   endtask

   task automatic wait_until_idle();
      do @(negedge clock);
      while (raw_items.size() != 0 || req_tvalid || expected_bytes.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Build one literal from random tokens; leave it open when asked
   task automatic queue_literal(bit terminate, inout int count);
      string esc_letters;
      string hex_chars;
      logic [7:0] body[$];
      int tokens;
      int digits;
      esc_letters = "ntrvf\\$\"'";
      hex_chars = "0123456789abcdefABCDEF";
      tokens = $urandom_range(1, 6);
      repeat (tokens) begin
         case ($urandom_range(0, 9))
            0, 1, 2: body.push_back(8'($urandom_range(32, 91)));
            3: body.push_back(8'($urandom_range(0, 255)));
            default: begin
               body.push_back(CH_BSLASH);
               case ($urandom_range(0, 6))
                  0, 1: body.push_back(esc_letters[$urandom_range(0, esc_letters.len() - 1)]);
                  2, 3: begin
                     body.push_back($urandom_range(0, 1) ? CH_UP_X : CH_LOW_X);
                     digits = $urandom_range(0, 2);
                     repeat (digits)
                        body.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
                  end
                  4, 5: begin
                     digits = $urandom_range(1, 3);
                     repeat (digits) body.push_back(8'($urandom_range(CH_ZERO, CH_SEVEN)));
                  end
                  default: body.push_back(8'($urandom_range(0, 255)));
               endcase
            end
         endcase
      end
      foreach (body[i]) push_item(body[i], terminate && (i == body.size() - 1));
      count += body.size();
   endtask

   // ------------------------------------------------------------------------
   // Sequence: reset, directed strings, then random phases across modes
   // ------------------------------------------------------------------------
   initial begin
      logic [1:0] modes[8];
      int count;
      modes = '{QM_SINGLE, QM_OTHER, QM_ALIAS, QM_DOUBLE,
                QM_SINGLE, QM_ALIAS, QM_DOUBLE, QM_OTHER};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, under the reset mode (double-quoted)
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b1);
      push_text("\\\"\\$\\\\");    // quote, dollar, backslash escapes
      push_text("\\x4G");          // hex run cut short
      push_text("\\777");          // octal overflow
      push_text("\\Xz");           // lone X
      push_text("\\q\\");          // unknown escape, trailing backslash
      push_text("\\x");            // trailing backslash-x
      push_text("\\12");           // digit run flushed by the end mark
      wait_until_idle();

      // Random phases; some end mid-literal so the mode changes under it
      for (int p = 0; p < 8; p++) begin
         idle_style = p;
         write_quote_mode(modes[p]);
         count = 0;
         while (count < PHASE_ITEMS) queue_literal(1'b1, count);
         queue_literal($urandom_range(0, 2) != 0, count);
         wait_until_idle();
      end

      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
